// File: design/assert_macros.svh
// Assertion macros shared by the access key table RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define AKMT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define AKMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/akmt_pkg.sv
// Package for the access key match table: field widths, command and status codes,
// microcode control word and the microprogram ROM. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package akmt_pkg;

    localparam int CMD_W        = 3;
    localparam int KEY_FIELD_W  = 56;
    localparam int SLOT_FIELD_W = 5;
    localparam int STATUS_W     = 2;
    localparam int S_TDATA_W    = 64;
    localparam int M_TDATA_W    = 64;
    localparam int M_PAD_W      = M_TDATA_W - 1 - STATUS_W - 1 - KEY_FIELD_W;
    localparam int DEF_SLOTS    = 16;
    localparam int DEF_KEY_BITS = 56;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_MASTER   = 3'd0,
        CMD_ADD          = 3'd1,
        CMD_CHECK        = 3'd2,
        CMD_CHECK_MASTER = 3'd3,
        CMD_REMOVE       = 3'd4,
        CMD_READ_SLOT    = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic [M_PAD_W-1:0]     pad;
        logic [KEY_FIELD_W-1:0] entry_key;
        logic                   entry_valid;
        t_status                status;
        logic                   granted;
    } t_mres;

    typedef enum logic [2:0] {
        C_JUMP,
        C_DISPATCH,
        C_EMPTY_OR_LAST,
        C_LAST,
        C_OUT_FREE
    } t_cond;

    typedef logic [3:0] t_upc;

    localparam t_upc U_IDLE = 4'd0;
    localparam t_upc U_SETM = 4'd1;
    localparam t_upc U_ADD  = 4'd2;
    localparam t_upc U_CHK  = 4'd3;
    localparam t_upc U_REM  = 4'd4;
    localparam t_upc U_MST  = 4'd5;
    localparam t_upc U_RDS  = 4'd6;
    localparam t_upc U_TAIL = 4'd7;
    localparam t_upc U_DONE = 4'd8;

    typedef struct packed {
        logic  in_rdy;
        logic  rd;
        logic  cmp;
        logic  clr;
        logic  cap;
        logic  wr;
        logic  add;
        logic  oor_chk;
        logic  idx_inc;
        logic  done;
        t_cond cond;
        t_upc  target;
    } t_ctrl;

    typedef struct packed {
        logic accept;
        logic empty;
        logic last;
        logic out_free;
    } t_flags;

    function automatic t_ctrl ucode(input t_upc a);
        t_ctrl cw;
        cw        = '0;
        cw.cond   = C_JUMP;
        cw.target = U_IDLE;
        case (a)
            U_IDLE: begin
                cw.in_rdy = 1'b1;
                cw.cond   = C_DISPATCH;
            end
            U_SETM: begin
                cw.wr     = 1'b1;
                cw.target = U_DONE;
            end
            U_ADD: begin
                cw.add     = 1'b1;
                cw.idx_inc = 1'b1;
                cw.cond    = C_EMPTY_OR_LAST;
                cw.target  = U_DONE;
            end
            U_CHK: begin
                cw.rd      = 1'b1;
                cw.cmp     = 1'b1;
                cw.idx_inc = 1'b1;
                cw.cond    = C_LAST;
                cw.target  = U_TAIL;
            end
            U_REM: begin
                cw.rd      = 1'b1;
                cw.cmp     = 1'b1;
                cw.clr     = 1'b1;
                cw.idx_inc = 1'b1;
                cw.cond    = C_LAST;
                cw.target  = U_TAIL;
            end
            U_MST: begin
                cw.rd     = 1'b1;
                cw.cmp    = 1'b1;
                cw.target = U_TAIL;
            end
            U_RDS: begin
                cw.rd      = 1'b1;
                cw.cap     = 1'b1;
                cw.oor_chk = 1'b1;
                cw.target  = U_TAIL;
            end
            U_TAIL: begin
                cw.target = U_DONE;
            end
            U_DONE: begin
                cw.done   = 1'b1;
                cw.cond   = C_OUT_FREE;
                cw.target = U_IDLE;
            end
            default: begin
                cw.target = U_IDLE;
            end
        endcase
        return cw;
    endfunction

    function automatic t_upc dispatch(input t_cmd c);
        t_upc a;
        case (c)
            CMD_SET_MASTER:   a = U_SETM;
            CMD_ADD:          a = U_ADD;
            CMD_CHECK:        a = U_CHK;
            CMD_CHECK_MASTER: a = U_MST;
            CMD_REMOVE:       a = U_REM;
            CMD_READ_SLOT:    a = U_RDS;
            default:          a = U_DONE;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// File: design/access_key_match_table.sv
// Access key match table: slave stream of requests, master stream of one result each.
// Request tuser = cmd; request tdata = key, slot. Result tdata = granted, status,
// entry_valid, entry_key.
// Channels: one request is taken at a time; o_s_axis_tready is high only while the
// sequencer waits for a request. Each request yields exactly one result.
// Steps from the accepting edge to the load that raises o_m_axis_tvalid:
//   check access, remove: one slot per cycle through every slot, then compare and load
//   add: one slot per cycle until an empty slot is found or the last slot is reached
//   check master, read slot: one read, then compare or capture, then load;
//   set master: one write, then load; unknown command: load only
// The next request can be taken in the cycle after the result is loaded.
// The result sits in an output register; a new request is taken while it waits.
// If the receiver stalls with a result still held, the next result waits in the
// sequencer until the register frees.
// Reset (synchronous, active low) empties every slot at once and drops any held
// result. Key store contents are not cleared; empty slots never compare.
// Depends on akmt_pkg, akmt_seq and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module access_key_match_table
    import akmt_pkg::*;
#(
    parameter int SLOTS    = DEF_SLOTS,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // key[55:0], slot[60:56], zero pad
    input  logic [CMD_W-1:0]     i_s_axis_tuser,  // cmd[2:0]
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata   // granted, status, entry_valid,
                                                  // entry_key, zero pad
);

    localparam int KW = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);
    localparam logic [SLOT_FIELD_W:0] SLOTS_EXT = (SLOT_FIELD_W + 1)'(SLOTS);

    t_ctrl  w_cw;
    t_flags w_flags;
    t_cmd   w_cmd;

    logic [KW-1:0]           w_key;
    logic [SLOT_FIELD_W-1:0] w_slot;
    logic                    w_s_acc;
    logic                    w_slot_oor;
    logic                    w_rd_en;
    logic                    w_wr_en;
    logic                    w_empty;
    logic                    w_last;
    logic                    w_match;
    logic                    w_out_free;
    logic                    w_load;

    logic [KW-1:0]    r_key;
    logic [SW-1:0]    r_idx;
    logic             r_oor;
    logic [KW-1:0]    r_mem [SLOTS];
    logic [KW-1:0]    r_rdata;
    logic [SLOTS-1:0] r_valid;

    logic          r_p_rd;
    logic          r_p_cmp;
    logic          r_p_clr;
    logic          r_p_cap;
    logic [SW-1:0] r_p_idx;
    logic          r_p_vbit;

    logic          r_granted;
    t_status       r_status;
    logic          r_evalid;
    logic [KW-1:0] r_ekey;

    logic  r_out_valid;
    t_mres r_out;

    assign w_cmd      = t_cmd'(i_s_axis_tuser);
    assign w_key      = i_s_axis_tdata[KW-1:0];
    assign w_slot     = i_s_axis_tdata[KEY_FIELD_W +: SLOT_FIELD_W];
    assign w_slot_oor = ({1'b0, w_slot} >= SLOTS_EXT);
    assign w_s_acc    = i_s_axis_tvalid && o_s_axis_tready;

    assign w_empty    = !r_valid[r_idx];
    assign w_last     = (r_idx == LAST_IDX);
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_rd_en    = w_cw.rd && !(w_cw.oor_chk && r_oor);
    assign w_wr_en    = w_cw.wr || (w_cw.add && w_empty);
    assign w_match    = r_p_vbit && (r_rdata == r_key);
    assign w_load     = w_cw.done && w_out_free;

    always_comb begin
        w_flags.accept   = w_s_acc;
        w_flags.empty    = w_empty;
        w_flags.last     = w_last;
        w_flags.out_free = w_out_free;
    end

    akmt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .i_cmd   (w_cmd),
        .o_ctrl  (w_cw)
    );

    // latch request
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_key <= w_key;
            r_oor <= w_slot_oor;
            if (w_cmd == CMD_READ_SLOT && !w_slot_oor) begin
                r_idx <= w_slot[SW-1:0];
            end else begin
                r_idx <= '0;
            end
        end else if (w_cw.idx_inc && !w_last) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // key store
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_idx] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_wr_en) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (r_p_rd && r_p_clr && w_match) begin
                r_valid[r_p_idx] <= 1'b0;
            end
        end
    end

    // compare stage, in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_rd <= 1'b0;
        end else begin
            r_p_rd <= w_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_cmp  <= w_cw.cmp;
        r_p_clr  <= w_cw.clr;
        r_p_cap  <= w_cw.cap;
        r_p_idx  <= r_idx;
        r_p_vbit <= r_valid[r_idx];
    end

    // result accumulation
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_granted <= 1'b0;
            r_status  <= ST_OK;
            r_evalid  <= 1'b0;
            r_ekey    <= '0;
        end else begin
            if (r_p_rd && r_p_cmp && w_match) begin
                r_granted <= 1'b1;
            end
            if (r_p_rd && r_p_cap) begin
                r_evalid <= r_p_vbit;
                r_ekey   <= r_p_vbit ? r_rdata : '0;
            end
            if (w_cw.add && !w_empty && w_last) begin
                r_status <= ST_FULL;
            end
            if (w_cw.oor_chk && r_oor) begin
                r_status <= ST_RANGE;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.pad         <= '0;
            r_out.entry_key   <= KEY_FIELD_W'(r_ekey);
            r_out.entry_valid <= r_evalid;
            r_out.status      <= r_status;
            r_out.granted     <= r_granted;
        end
    end

    assign o_s_axis_tready = w_cw.in_rdy && i_rst_n;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    `AKMT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_s_acc, !o_s_axis_tready)
    `AKMT_ASSERT_IMPL(a_load_when_free, i_clk, i_rst_n, w_load,
                      (!r_out_valid || i_m_axis_tready))
    `AKMT_ASSERT_IMPL(a_range_is_empty, i_clk, i_rst_n,
                      (r_out_valid && r_out.status == ST_RANGE),
                      ((r_out.entry_key == '0) && !r_out.entry_valid))
    `AKMT_ASSERT_IMPL(a_grant_only_ok, i_clk, i_rst_n, (r_out_valid && r_out.granted),
                      (r_out.status == ST_OK))

endmodule

`default_nettype wire

// File: design/akmt_seq.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on akmt_pkg for the control word, the ROM and the dispatch table.
`timescale 1ns / 1ps
`default_nettype none

module akmt_seq
    import akmt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    input  t_cmd   i_cmd,
    output t_ctrl  o_ctrl
);

    t_upc  r_upc;
    t_upc  n_upc;
    t_ctrl w_cw;

    always_comb begin
        w_cw = ucode(r_upc);
    end

    always_comb begin
        n_upc = r_upc;
        case (w_cw.cond)
            C_JUMP:          n_upc = w_cw.target;
            C_DISPATCH:      if (i_flags.accept) n_upc = dispatch(i_cmd);
            C_EMPTY_OR_LAST: if (i_flags.empty || i_flags.last) n_upc = w_cw.target;
            C_LAST:          if (i_flags.last) n_upc = w_cw.target;
            C_OUT_FREE:      if (i_flags.out_free) n_upc = w_cw.target;
            default:         n_upc = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctrl = w_cw;

endmodule

`default_nettype wire

// File: sim/tb_access_key_match_table.sv
// Testbench for access_key_match_table: drives request streams and checks each result
// against a cycle-free predictor of the key table. Depends on akmt_pkg and the RTL.
`timescale 1ns / 1ps

module tb_access_key_match_table;
    import akmt_pkg::*;

    localparam int NUM_SLOTS   = DEF_SLOTS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;
    localparam int TAIL_ITEMS  = 200;
    localparam int REPORT_MAX  = 10;

    localparam logic [CMD_W-1:0] CMD_BAD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_BAD7 = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]       cmd;
        logic                   granted;
        t_status                status;
        logic                   entry_valid;
        logic [KEY_FIELD_W-1:0] entry_key;
    } t_verdict;

    logic                 i_clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [CMD_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    t_mres                seen_res;

    logic [KEY_FIELD_W-1:0] card_keys [NUM_SLOTS];
    logic                   slot_used [NUM_SLOTS];
    t_verdict               verdict_q [$];
    int                     fail_count;
    int                     cycle_count;
    bit                     idle_on;

    assign seen_res = m_tdata;

    access_key_match_table u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // key[55:0], slot[60:56], zero pad
        .i_s_axis_tuser  (s_tuser),   // cmd[2:0]
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)    // granted, status[1:0], entry_valid, entry_key[55:0], pad
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int count_used();
        int n;
        n = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_used[i]) n++;
        end
        return n;
    endfunction

    function automatic t_verdict predict_table_response(input logic [CMD_W-1:0] cmd,
                                                        input logic [KEY_FIELD_W-1:0] key,
                                                        input logic [SLOT_FIELD_W-1:0] slot);
        t_verdict v;
        bit       placed;
        v.cmd         = cmd;
        v.granted     = 1'b0;
        v.status      = ST_OK;
        v.entry_valid = 1'b0;
        v.entry_key   = '0;
        placed        = 1'b0;
        case (cmd)
            CMD_SET_MASTER: begin
                card_keys[0] = key;
                slot_used[0] = 1'b1;
            end
            CMD_ADD: begin
                v.status = ST_FULL;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!placed && !slot_used[i]) begin
                        card_keys[i] = key;
                        slot_used[i] = 1'b1;
                        placed       = 1'b1;
                        v.status     = ST_OK;
                    end
                end
            end
            CMD_CHECK: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (slot_used[i] && card_keys[i] == key) v.granted = 1'b1;
                end
            end
            CMD_CHECK_MASTER: begin
                if (slot_used[0] && card_keys[0] == key) v.granted = 1'b1;
            end
            CMD_REMOVE: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (slot_used[i] && card_keys[i] == key) begin
                        slot_used[i] = 1'b0;
                        v.granted    = 1'b1;
                    end
                end
            end
            CMD_READ_SLOT: begin
                if (slot >= NUM_SLOTS) begin
                    v.status = ST_RANGE;
                end else if (slot_used[slot]) begin
                    v.entry_valid = 1'b1;
                    v.entry_key   = card_keys[slot];
                end
            end
            default: begin
            end
        endcase
        return v;
    endfunction

    function automatic logic [KEY_FIELD_W-1:0] rand_key();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[KEY_FIELD_W-1:0];
    endfunction

    function automatic logic [KEY_FIELD_W-1:0] pick_card_key();
        int sel;
        int idx;
        sel = $urandom_range(0, 99);
        if (sel < 65 && count_used() != 0) begin
            do idx = $urandom_range(0, NUM_SLOTS - 1); while (!slot_used[idx]);
            return card_keys[idx];
        end
        if (sel < 72) return '0;
        if (sel < 79) return '1;
        return rand_key();
    endfunction

    function automatic logic [SLOT_FIELD_W-1:0] pick_slot();
        if ($urandom_range(0, 3) == 0) return SLOT_FIELD_W'($urandom_range(NUM_SLOTS, 31));
        return SLOT_FIELD_W'($urandom_range(0, NUM_SLOTS - 1));
    endfunction

    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [KEY_FIELD_W-1:0] key,
                                input logic [SLOT_FIELD_W-1:0] slot);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 11);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - SLOT_FIELD_W - KEY_FIELD_W){1'b0}}, slot, key};
        s_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        verdict_q.push_back(predict_table_response(cmd, key, slot));
    endtask

    task automatic test_empty_table();
        send_request(CMD_CHECK, '0, '0);
        send_request(CMD_READ_SLOT, '1, 5'd31);
        send_request(CMD_BAD6, rand_key(), 5'd16);
        send_request(CMD_BAD7, '1, '1);
    endtask

    task automatic test_master_key();
        send_request(CMD_SET_MASTER, '1, '0);
        send_request(CMD_CHECK_MASTER, '1, '0);
        send_request(CMD_ADD, '1, '0);
        send_request(CMD_REMOVE, '1, '0);
        send_request(CMD_ADD, '0, '0);
        send_request(CMD_READ_SLOT, rand_key(), '0);
    endtask

    task automatic test_fill_table();
        while (count_used() < NUM_SLOTS) send_request(CMD_ADD, rand_key(), pick_slot());
        send_request(CMD_ADD, rand_key(), pick_slot());
    endtask

    task automatic test_random_traffic(input int n_items);
        int               pick;
        int               add_w;
        logic [CMD_W-1:0] cmd;
        repeat (n_items) begin
            add_w = (count_used() < NUM_SLOTS / 2) ? 30 : 14;
            pick  = $urandom_range(0, 99);
            if (pick < 6)
                cmd = CMD_SET_MASTER;
            else if (pick < 6 + add_w)
                cmd = CMD_ADD;
            else if (pick < 46)
                cmd = CMD_REMOVE;
            else if (pick < 68)
                cmd = CMD_CHECK;
            else if (pick < 80)
                cmd = CMD_CHECK_MASTER;
            else if (pick < 96)
                cmd = CMD_READ_SLOT;
            else
                cmd = ($urandom_range(0, 1) != 0) ? CMD_BAD7 : CMD_BAD6;
            send_request(cmd, pick_card_key(), pick_slot());
        end
    endtask

    initial begin
        m_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result: %h", m_tdata);
            end else begin
                if (seen_res.granted     !== verdict_q[0].granted
                 || seen_res.status      !== verdict_q[0].status
                 || seen_res.entry_valid !== verdict_q[0].entry_valid
                 || seen_res.entry_key   !== verdict_q[0].entry_key) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("cmd %0d: exp g=%b st=%0d v=%b k=%h, got g=%b st=%0d v=%b k=%h",
                                 verdict_q[0].cmd, verdict_q[0].granted, verdict_q[0].status,
                                 verdict_q[0].entry_valid, verdict_q[0].entry_key,
                                 seen_res.granted, seen_res.status,
                                 seen_res.entry_valid, seen_res.entry_key);
                end
                void'(verdict_q.pop_front());
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        fail_count = 0;
        idle_on    = 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            card_keys[i] = '0;
            slot_used[i] = 1'b0;
        end
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_master_key();
        test_fill_table();
        test_random_traffic(1350);
        idle_on = 1'b0;
        test_random_traffic(TAIL_ITEMS);

        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && verdict_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
